// ----- design/soa_pkg.sv -----
// Shared types and constants for the slab object allocator.
package soa_pkg;

   localparam int NUM_SLABS   = 16;
   localparam int MAX_OBJECTS = 256;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [1:0] STATUS_BAD_FREE  = 2'd2;

   localparam logic [1:0] CLS_NONE    = 2'd0;
   localparam logic [1:0] CLS_FREE    = 2'd1;
   localparam logic [1:0] CLS_PARTIAL = 2'd2;
   localparam logic [1:0] CLS_FULL    = 2'd3;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam int WORD_BITS = 64;

   localparam logic [0:0] REG_OBJECTS = 1'b0;
   localparam logic [0:0] REG_POOL    = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic load;      // capture request
      logic clear;     // start clearing pass
      logic scan;      // read next bitmap word
      logic commit;    // apply update
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_done;
      logic scan_done;
      logic commit_done;
   } stat_type;

endpackage

// ----- design/soa_datapath.sv -----
// Datapath: bitmap memory, per-slab bookkeeping, list links and result register.
module soa_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  soa_pkg::cmd_type     cmd,
   output soa_pkg::stat_type    stat,
   input  logic                 req_op,
   input  logic [3:0]           req_slab,
   input  logic [7:0]           req_index,
   input  logic [8:0]           objects_per_slab,
   input  logic [4:0]           pool_slabs,
   output logic [1:0]           res_status,
   output logic [3:0]           res_slab,
   output logic [7:0]           res_index
);
   import soa_pkg::*;

   localparam int SW   = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
   localparam int LW   = SW + 1;
   localparam int WPS  = (MAX_OBJECTS + WORD_BITS - 1) / WORD_BITS;
   localparam int WW   = (WPS > 1) ? $clog2(WPS) : 1;
   localparam int DEP  = NUM_SLABS * WPS;
   localparam int AW   = $clog2(DEP);
   localparam int CW   = $clog2(MAX_OBJECTS + 1);
   localparam int OW   = $clog2(MAX_OBJECTS);
   localparam int GW   = $clog2(NUM_SLABS + 1);
   localparam logic [LW-1:0] NIL = {LW{1'b1}};

   // Bitmap memory, one word read per cycle
   logic [WORD_BITS-1:0] bitmap_mem [DEP];
   logic [WORD_BITS-1:0] rd_word_ff;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [AW-1:0]        mem_raddr;

   // Per-slab bookkeeping
   logic [CW-1:0] use_ff   [NUM_SLABS];
   logic [1:0]    cls_ff   [NUM_SLABS];
   logic [LW-1:0] next_ff  [NUM_SLABS];
   logic [LW-1:0] prev_ff  [NUM_SLABS];
   logic [LW-1:0] phead_ff, fhead_ff;
   logic [GW-1:0] grown_ff;

   // Request and working registers
   logic          op_ff;
   logic [SW-1:0] slab_ff;
   logic [7:0]    idx_ff;
   logic          bad_ff;
   logic [WW:0]   word_ff;
   logic          rd_pend_ff;
   logic          found_ff;
   logic [OW-1:0] hit_ff;
   logic [AW:0]   clr_ff;
   logic          clearing_ff;
   logic          scanning_ff;
   logic          done_ff;
   logic          cdone_ff;

   logic [1:0] status_ff;
   logic [3:0] rslab_ff;
   logic [7:0] rindex_ff;

   logic [CW-1:0] cap;
   logic [GW-1:0] plim;

   // Clamp the registers
   always_comb begin
      if (objects_per_slab == '0)
         cap = CW'(1);
      else if (32'(objects_per_slab) > MAX_OBJECTS)
         cap = CW'(MAX_OBJECTS);
      else
         cap = CW'(objects_per_slab);
      if (pool_slabs == '0)
         plim = GW'(1);
      else if (32'(pool_slabs) > NUM_SLABS)
         plim = GW'(NUM_SLABS);
      else
         plim = GW'(pool_slabs);
   end

   // Lowest clear bit in the word just read
   logic          word_hit;
   logic [5:0]    word_pos;
   always_comb begin
      word_hit = 1'b0;
      word_pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!rd_word_ff[b]) begin
            word_hit = 1'b1;
            word_pos = 6'(b);
         end
      end
   end

   // Slab chosen for allocation, found from list heads or else the growth count
   logic [LW-1:0] alloc_slab;
   logic          need_grow;
   logic          exhausted;
   always_comb begin
      need_grow = (phead_ff == NIL) && (fhead_ff == NIL);
      exhausted = need_grow && (grown_ff >= plim);
      if (phead_ff != NIL)
         alloc_slab = phead_ff;
      else if (fhead_ff != NIL)
         alloc_slab = fhead_ff;
      else
         alloc_slab = LW'(grown_ff);
   end

   logic [AW-1:0] cur_addr;
   assign cur_addr = op_ff ? AW'(32'(slab_ff) * WPS + 32'(idx_ff) / WORD_BITS)
                           : AW'(32'(alloc_slab[SW-1:0]) * WPS + 32'(word_ff[WW-1:0]));
   assign mem_raddr = cur_addr;

   // Candidate object index from scan
   logic [CW:0] cand;
   assign cand = (CW+1)'(32'(word_ff[WW-1:0]) * WORD_BITS + 32'(word_pos));

   // Memory write port; an allocate without a free bit writes nothing
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cur_addr;
      mem_wdata = rd_word_ff;
      if (clearing_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff[AW-1:0];
         mem_wdata = '0;
      end else if (cmd.commit && !bad_ff && (op_ff == OP_FREE || found_ff)) begin
         mem_we = 1'b1;
         if (op_ff == OP_FREE) begin
            mem_wdata = rd_word_ff & ~(WORD_BITS'(1) << idx_ff[5:0]);
         end else begin
            mem_waddr = AW'(32'(alloc_slab[SW-1:0]) * WPS + 32'(hit_ff) / WORD_BITS);
            mem_wdata = rd_word_ff | (WORD_BITS'(1) << hit_ff[5:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         bitmap_mem[mem_waddr] <= mem_wdata;
      rd_word_ff <= bitmap_mem[mem_raddr];
   end

   // Clearing pass and scan sequencing; hold scan done until the commit
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
         scanning_ff <= 1'b0;
         rd_pend_ff  <= 1'b0;
         done_ff     <= 1'b0;
         found_ff    <= 1'b0;
         word_ff     <= '0;
      end else begin
         if (cmd.commit)
            done_ff <= 1'b0;
         if (cmd.clear) begin
            clearing_ff <= 1'b1;
            clr_ff      <= '0;
         end else if (clearing_ff) begin
            if (32'(clr_ff) == DEP - 1)
               clearing_ff <= 1'b0;
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.scan) begin
            scanning_ff <= 1'b1;
            rd_pend_ff  <= 1'b1;
            word_ff     <= '0;
            found_ff    <= 1'b0;
         end else if (scanning_ff) begin
            if (rd_pend_ff) begin
               rd_pend_ff <= 1'b0;
            end else if (op_ff == OP_FREE || bad_ff) begin
               scanning_ff <= 1'b0;
               done_ff     <= 1'b1;
            end else if (word_hit && cand < (CW+1)'(cap)) begin
               found_ff    <= 1'b1;
               hit_ff      <= OW'(cand);
               scanning_ff <= 1'b0;
               done_ff     <= 1'b1;
            end else if (32'(word_ff) + 1 >= WPS ||
                         (CW+1)'(32'(word_ff + 1'b1) * WORD_BITS) >= (CW+1)'(cap)) begin
               scanning_ff <= 1'b0;
               done_ff     <= 1'b1;
            end else begin
               word_ff    <= word_ff + 1'b1;
               rd_pend_ff <= 1'b1;
            end
         end
      end
   end

   // Capture request
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         slab_ff <= SW'(req_slab);
         idx_ff  <= req_index;
         bad_ff  <= (req_op == OP_FREE) &&
                    (32'(req_slab) >= NUM_SLABS || 32'(req_index) >= 32'(cap));
      end else if (op_ff == OP_ALLOC && cmd.scan) begin
         bad_ff <= exhausted;
      end
   end

   // Free bit check on the word read for a free
   logic free_ok;
   assign free_ok = rd_word_ff[idx_ff[5:0]] && (use_ff[slab_ff] != '0);

   // Apply list and count updates
   always_ff @(posedge clock) begin
      logic [LW-1:0] s;
      logic [LW-1:0] n, p;
      s = '0;
      n = '0;
      p = '0;
      if (reset || cmd.clear) begin
         for (int k = 0; k < NUM_SLABS; k++) begin
            use_ff[k]  <= '0;
            cls_ff[k]  <= CLS_NONE;
            next_ff[k] <= NIL;
            prev_ff[k] <= NIL;
         end
         phead_ff <= NIL;
         fhead_ff <= NIL;
         grown_ff <= '0;
         cdone_ff <= 1'b0;
      end else begin
         cdone_ff <= cmd.commit;
         if (cmd.commit) begin
            if (op_ff == OP_ALLOC) begin
               if (!bad_ff && found_ff) begin
                  s = alloc_slab;
                  if (phead_ff == NIL) begin
                     // move slab from free list (or growth) to partial head
                     if (need_grow) begin
                        grown_ff <= grown_ff + 1'b1;
                        fhead_ff <= NIL;
                     end else begin
                        n = next_ff[s[SW-1:0]];
                        fhead_ff <= n;
                        if (n != NIL)
                           prev_ff[n[SW-1:0]] <= NIL;
                     end
                     phead_ff <= s;
                     next_ff[s[SW-1:0]] <= NIL;
                     prev_ff[s[SW-1:0]] <= NIL;
                     cls_ff[s[SW-1:0]]  <= CLS_PARTIAL;
                  end
                  use_ff[s[SW-1:0]] <= use_ff[s[SW-1:0]] + 1'b1;
                  if (use_ff[s[SW-1:0]] + 1'b1 >= cap) begin
                     cls_ff[s[SW-1:0]] <= CLS_FULL;
                     if (phead_ff == NIL) begin
                        phead_ff <= NIL;
                     end else begin
                        n = next_ff[s[SW-1:0]];
                        phead_ff <= n;
                        if (n != NIL)
                           prev_ff[n[SW-1:0]] <= NIL;
                     end
                     next_ff[s[SW-1:0]] <= NIL;
                     prev_ff[s[SW-1:0]] <= NIL;
                  end
               end else if (!bad_ff && need_grow) begin
                  // grown slab with no room: put it on the partial list
                  s = alloc_slab;
                  grown_ff <= grown_ff + 1'b1;
                  cls_ff[s[SW-1:0]] <= CLS_PARTIAL;
                  phead_ff <= s;
               end else if (!bad_ff && phead_ff == NIL) begin
                  s = alloc_slab;
                  n = next_ff[s[SW-1:0]];
                  fhead_ff <= n;
                  if (n != NIL)
                     prev_ff[n[SW-1:0]] <= NIL;
                  next_ff[s[SW-1:0]] <= NIL;
                  cls_ff[s[SW-1:0]] <= CLS_PARTIAL;
                  phead_ff <= s;
               end
            end else if (!bad_ff && free_ok) begin
               s = LW'(slab_ff);
               if (use_ff[slab_ff] == CW'(1)) begin
                  // slab empties: unlink from partial if there, push on free
                  if (cls_ff[slab_ff] == CLS_PARTIAL) begin
                     n = next_ff[slab_ff];
                     p = prev_ff[slab_ff];
                     if (p != NIL)
                        next_ff[p[SW-1:0]] <= n;
                     else
                        phead_ff <= n;
                     if (n != NIL)
                        prev_ff[n[SW-1:0]] <= p;
                  end
                  next_ff[slab_ff] <= fhead_ff;
                  prev_ff[slab_ff] <= NIL;
                  if (fhead_ff != NIL)
                     prev_ff[fhead_ff[SW-1:0]] <= s;
                  fhead_ff <= s;
                  cls_ff[slab_ff] <= CLS_FREE;
               end else if (cls_ff[slab_ff] == CLS_FULL) begin
                  next_ff[slab_ff] <= phead_ff;
                  prev_ff[slab_ff] <= NIL;
                  if (phead_ff != NIL)
                     prev_ff[phead_ff[SW-1:0]] <= s;
                  phead_ff <= s;
                  cls_ff[slab_ff] <= CLS_PARTIAL;
               end
               use_ff[slab_ff] <= use_ff[slab_ff] - 1'b1;
            end
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= STATUS_OK;
         rslab_ff  <= '0;
         rindex_ff <= '0;
         if (op_ff == OP_ALLOC) begin
            if (bad_ff || !found_ff) begin
               status_ff <= STATUS_EXHAUSTED;
            end else begin
               rslab_ff  <= 4'(alloc_slab[SW-1:0]);
               rindex_ff <= 8'(hit_ff);
            end
         end else if (bad_ff || !free_ok) begin
            status_ff <= STATUS_BAD_FREE;
         end
      end
   end

   // Status to the controller and result outputs
   assign stat.clear_done  = !clearing_ff;
   assign stat.scan_done   = done_ff;
   assign stat.commit_done = cdone_ff;
   assign res_status = status_ff;
   assign res_slab   = rslab_ff;
   assign res_index  = rindex_ff;

endmodule

// ----- design/soa_control.sv -----
// Controller: sequences clear, request capture, bitmap scan, commit and response.
module soa_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic              cfg_clear,
   output soa_pkg::cmd_type  cmd,
   input  soa_pkg::stat_type stat
);
   import soa_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_START  = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_COMMIT = 3'd4;
   localparam logic [2:0] ST_WAIT   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == ST_IDLE) && !cfg_clear;
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.clear    = cfg_clear;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_done)
               state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (cfg_clear)
               state_in = ST_CLEAR;
            else if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.scan = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.scan_done && (!rsp_valid_ff || rsp_tready)) begin
               cmd.commit = 1'b1;
               state_in   = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_WAIT;
         end
         ST_WAIT: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- design/slab_object_allocator_core.sv -----
// Top level of the slab object allocator: CSR port, controller and datapath.
//
//  channel | direction | contents
//  req     | in        | tdata: opcode, slab_id, object_index
//  rsp     | out       | tdata: status, granted_slab, granted_index
//  csr     | in/out    | objects_per_slab (0x0), pool_slabs (0x4)
//
// A free, a refused allocate or an allocate that hits in the first bitmap word
// reads one word before its commit; each further word scanned adds a read and a
// test on the single read port, up to 4 words at 256 objects. After the commit the
// controller passes a wait state and returns to idle, where the next item is taken.
// After reset and after each objects_per_slab write a clearing pass over all
// NUM_SLABS*words bitmap words runs; after reset or a write while idle, no item
// is taken until it ends. The result waits in an output register; the next item
// is taken while it waits, its commit holds until the slot frees.
module slab_object_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [0] opcode, [4:1] slab_id, [12:5] object_index
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [1:0] status, [5:2] granted_slab, [13:6] granted_index
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import soa_pkg::*;

   logic [8:0] objects_ff;
   logic [4:0] pool_ff;
   logic       wr_en;
   logic       cfg_clear;
   cmd_type    cmd;
   stat_type   stat;
   logic [1:0] res_status;
   logic [3:0] res_slab;
   logic [7:0] res_index;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign cfg_clear = wr_en && (csr_paddr[2] == REG_OBJECTS);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         objects_ff <= 9'd256;
         pool_ff    <= 5'd16;
      end else if (wr_en) begin
         if (csr_paddr[2] == REG_OBJECTS)
            objects_ff <= csr_pwdata[8:0];
         else
            pool_ff <= csr_pwdata[4:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_POOL) ? {27'd0, pool_ff} : {23'd0, objects_ff};

   soa_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cfg_clear  (cfg_clear),
      .cmd        (cmd),
      .stat       (stat)
   );

   soa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_op           (req_tdata[0]),
      .req_slab         (req_tdata[4:1]),
      .req_index        (req_tdata[12:5]),
      .objects_per_slab (objects_ff),
      .pool_slabs       (pool_ff),
      .res_status       (res_status),
      .res_slab         (res_slab),
      .res_index        (res_index)
   );

   assign rsp_tdata = {2'b00, res_index, res_slab, res_status};

endmodule

// ----- design/soa_checker.sv -----
// Port-level checker for the slab object allocator, bound to the top level.
module soa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        csr_pready
);
   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Status code is never 3
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("bad status code");

   // Non-ok results carry zero slab and index
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != 2'd0 |-> rsp_tdata[13:2] == 12'd0)
      else $error("failed result carries grant");

   // No new transaction directly after one is accepted
   a_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted twice in a row");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
endmodule

bind slab_object_allocator_core soa_checker u_soa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);
